>>> design/tbb_pkg.sv
// Shared types, constants and helper functions for the threshold bounding box unit.
package tbb_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int COORD_W     = $clog2(MAX_DIM);
   localparam int DIM_W       = COORD_W + 1;
   localparam int PIXEL_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = DIM_W;

   typedef logic [COORD_W-1:0] tbb_coord_type;
   typedef logic [DIM_W-1:0]   tbb_dim_type;
   typedef logic [PIXEL_W-1:0] tbb_pixel_type;

   localparam tbb_coord_type COORD_MAX = '1;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEVEL_LOW    = 3'd0,
      CSR_LEVEL_HIGH   = 3'd1,
      CSR_MARGIN       = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } tbb_csr_index_type;

   typedef struct packed {
      tbb_pixel_type level_low;
      tbb_pixel_type level_high;
      logic [7:0]    margin;
      tbb_dim_type   image_width;
      tbb_dim_type   image_height;
   } tbb_cfg_type;

   localparam tbb_cfg_type CFG_RESET = '{
      level_low:    8'd0,
      level_high:   8'd255,
      margin:       8'd0,
      image_width:  DIM_W'(MAX_DIM),
      image_height: DIM_W'(MAX_DIM)
   };

   typedef struct packed {
      tbb_pixel_type pixel_value;
      logic          frame_end;
   } tbb_req_type;

   typedef struct packed {
      logic [11:0] box_left;
      logic [11:0] box_top;
      logic [12:0] box_width;
      logic [12:0] box_height;
      logic        box_empty;
   } tbb_rsp_type;

   // Extent of the selected pixels; also carried down the result pipe.
   typedef struct packed {
      logic          any_selected;
      tbb_coord_type least_column;
      tbb_coord_type greatest_column;
      tbb_coord_type least_row;
      tbb_coord_type greatest_row;
   } tbb_track_type;

   localparam tbb_track_type TRACK_CLEAR = '{
      any_selected:    1'b0,
      least_column:    '1,
      greatest_column: '0,
      least_row:       '1,
      greatest_row:    '0
   };

   // Last valid index of a dimension; zero acts as one, oversize as MAX_DIM.
   function automatic tbb_coord_type tbb_dim_last(input tbb_dim_type dim);
      tbb_coord_type last;
      if (dim == '0) begin
         last = '0;
      end else if (dim > DIM_W'(MAX_DIM)) begin
         last = COORD_W'(MAX_DIM - 1);
      end else begin
         last = COORD_W'(dim - DIM_W'(1));
      end
      return last;
   endfunction

   function automatic tbb_coord_type tbb_clamp(input tbb_coord_type v,
                                               input tbb_coord_type last);
      return (v > last) ? last : v;
   endfunction

endpackage

>>> design/threshold_bounding_box_unit.sv
// Top level of the threshold bounding box unit: register file, tracker and result pipeline.
//
// Grayscale pixels enter one beat per ready clock in raster order on the req_ channel; the
// unit counts column and row itself against image_width and keeps the least and
// greatest column and row of every pixel whose value lies in [level_low, level_high].
// The beat flagged frame_end is examined like any other, then closes the frame: its
// extent is snapshotted, the tracker clears for the next frame, and one rsp_ beat
// follows with the box widened by margin and clamped to the image (or box_empty set
// and an all-zero box). Sustained rate is one pixel per clock, set by the per-pixel
// compare and min/max update in the tracker, when rsp_ready does not hold the result pipe;
// frame ends may also come back to back. A result passes through the snapshot, clamp,
// margin and output registers to rsp_, and is held there while rsp_ready is low.
// Registers are written on the csr_ channel, always ready, and should be changed
// only while no result is pending. A width or height of 0 acts as 1, above 4096 as 4096.
module threshold_bounding_box_unit (
   input  logic                            clock,
   input  logic                            reset,
   // pixel beats
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tbb_pkg::tbb_req_type            req_data,
   // box beats
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tbb_pkg::tbb_rsp_type            rsp_data,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tbb_pkg::*;

   tbb_cfg_type   cfg;
   logic          snap_valid;
   logic          snap_ready;
   tbb_track_type snap_data;

   tbb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // per-pixel position and extent tracking
   tbb_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data)
   );

   // frame-end extent to box, with output register toward rsp_
   tbb_box_calc u_box_calc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (snap_valid),
      .in_ready  (snap_ready),
      .in_data   (snap_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // non-empty box always has a size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.box_empty |->
         rsp_data.box_width != 13'd0 && rsp_data.box_height != 13'd0)
      else $error("non-empty box with zero size");

   // empty result carries an all-zero box
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.box_empty |->
         rsp_data.box_left == 12'd0 && rsp_data.box_top == 12'd0 &&
         rsp_data.box_width == 13'd0 && rsp_data.box_height == 13'd0)
      else $error("empty result with nonzero box");

   // box stays inside the image
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.box_empty |->
         14'(rsp_data.box_left) + 14'(rsp_data.box_width) <=
            14'(tbb_dim_last(cfg.image_width)) + 14'd1 &&
         14'(rsp_data.box_top) + 14'(rsp_data.box_height) <=
            14'(tbb_dim_last(cfg.image_height)) + 14'd1)
      else $error("box extends past the image");

endmodule

>>> design/tbb_csr.sv
// Configuration register file for the threshold bounding box unit.
module tbb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tbb_pkg::tbb_cfg_type            cfg
);
   import tbb_pkg::*;

   tbb_cfg_type cfg_ff;
   tbb_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LEVEL_LOW:    cfg_in.level_low    = csr_wdata[PIXEL_W-1:0];
            CSR_LEVEL_HIGH:   cfg_in.level_high   = csr_wdata[PIXEL_W-1:0];
            CSR_MARGIN:       cfg_in.margin       = csr_wdata[7:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[DIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/tbb_tracker.sv
// Raster position counters and extent tracking; snapshots the extent at frame end.
module tbb_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  tbb_pkg::tbb_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tbb_pkg::tbb_req_type   req_data,
   output logic                   snap_valid,
   input  logic                   snap_ready,
   output tbb_pkg::tbb_track_type snap_data
);
   import tbb_pkg::*;

   tbb_coord_type col_ff, col_in;
   tbb_coord_type row_ff, row_in;
   tbb_track_type track_ff, track_in;
   tbb_track_type snap_ff, snap_in;
   logic          snap_valid_ff, snap_valid_in;

   tbb_coord_type w_last;
   tbb_coord_type x;
   logic          sel;
   logic          snap_free;
   logic          accept;
   tbb_track_type track_upd;

   assign snap_free  = !snap_valid_ff || snap_ready;
   assign req_ready  = snap_free;
   assign accept     = req_valid && snap_free;
   assign snap_valid = snap_valid_ff;
   assign snap_data  = snap_ff;

   always_comb begin
      w_last = tbb_dim_last(cfg.image_width);
      // column past a shrunken width is taken as column 0 of the current row
      x   = (col_ff > w_last) ? '0 : col_ff;
      sel = (req_data.pixel_value >= cfg.level_low) &&
            (req_data.pixel_value <= cfg.level_high);

      track_upd = track_ff;
      if (sel) begin
         if (!track_ff.any_selected || x < track_ff.least_column)
            track_upd.least_column = x;
         if (!track_ff.any_selected || x > track_ff.greatest_column)
            track_upd.greatest_column = x;
         if (!track_ff.any_selected || row_ff < track_ff.least_row)
            track_upd.least_row = row_ff;
         if (!track_ff.any_selected || row_ff > track_ff.greatest_row)
            track_upd.greatest_row = row_ff;
         track_upd.any_selected = 1'b1;
      end

      col_in        = col_ff;
      row_in        = row_ff;
      track_in      = track_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff && !snap_ready;

      if (accept) begin
         if (!req_data.frame_end) begin
            track_in = track_upd;
            if (x >= w_last) begin
               col_in = '0;
               row_in = (row_ff < COORD_MAX) ? row_ff + COORD_W'(1) : row_ff;
            end else begin
               col_in = x + COORD_W'(1);
            end
         end else begin
            col_in        = '0;
            row_in        = '0;
            track_in      = TRACK_CLEAR;
            snap_in       = track_upd;
            snap_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         track_ff      <= TRACK_CLEAR;
         snap_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         track_ff      <= track_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

endmodule

>>> design/tbb_box_calc.sv
// Result pipeline: clamp to image, apply margin, form box and hold it for the consumer.
module tbb_box_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  tbb_pkg::tbb_cfg_type   cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tbb_pkg::tbb_track_type in_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tbb_pkg::tbb_rsp_type   rsp_data
);
   import tbb_pkg::*;

   tbb_track_type clamp_ff, clamp_in;
   tbb_track_type marg_ff, marg_in;
   tbb_rsp_type   rsp_ff, rsp_in;
   logic          b_valid_ff, b_valid_in;
   logic          c_valid_ff, c_valid_in;
   logic          out_valid_ff, out_valid_in;

   logic          out_free, c_free, b_free;
   tbb_coord_type w_last, h_last;
   tbb_coord_type m;
   tbb_dim_type   x1_sum, y1_sum;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign c_free    = !c_valid_ff || out_free;
   assign b_free    = !b_valid_ff || c_free;
   assign in_ready  = b_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      w_last = tbb_dim_last(cfg.image_width);
      h_last = tbb_dim_last(cfg.image_height);
      m      = COORD_W'(cfg.margin);

      // clamp kept extent to the image
      clamp_in                 = in_data;
      clamp_in.least_column    = tbb_clamp(in_data.least_column, w_last);
      clamp_in.greatest_column = tbb_clamp(in_data.greatest_column, w_last);
      clamp_in.least_row       = tbb_clamp(in_data.least_row, h_last);
      clamp_in.greatest_row    = tbb_clamp(in_data.greatest_row, h_last);

      // widen by margin, saturate at the image edges
      marg_in              = clamp_ff;
      marg_in.least_column = (clamp_ff.least_column > m) ?
                             clamp_ff.least_column - m : '0;
      marg_in.least_row    = (clamp_ff.least_row > m) ?
                             clamp_ff.least_row - m : '0;
      x1_sum = DIM_W'(clamp_ff.greatest_column) + DIM_W'(m);
      y1_sum = DIM_W'(clamp_ff.greatest_row) + DIM_W'(m);
      marg_in.greatest_column = (x1_sum > DIM_W'(w_last)) ? w_last : x1_sum[COORD_W-1:0];
      marg_in.greatest_row    = (y1_sum > DIM_W'(h_last)) ? h_last : y1_sum[COORD_W-1:0];

      if (!marg_ff.any_selected) begin
         rsp_in           = '0;
         rsp_in.box_empty = 1'b1;
      end else begin
         rsp_in.box_left   = 12'(marg_ff.least_column);
         rsp_in.box_top    = 12'(marg_ff.least_row);
         rsp_in.box_width  = 13'(DIM_W'(marg_ff.greatest_column) -
                                 DIM_W'(marg_ff.least_column) + DIM_W'(1));
         rsp_in.box_height = 13'(DIM_W'(marg_ff.greatest_row) -
                                 DIM_W'(marg_ff.least_row) + DIM_W'(1));
         rsp_in.box_empty  = 1'b0;
      end

      b_valid_in   = b_free   ? in_valid   : b_valid_ff;
      c_valid_in   = c_free   ? b_valid_ff : c_valid_ff;
      out_valid_in = out_free ? c_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free)   clamp_ff <= clamp_in;
      if (c_free)   marg_ff  <= marg_in;
      if (out_free) rsp_ff   <= rsp_in;
   end

endmodule

>>> sim/tbb_box_scoreboard.sv
`timescale 1ns / 1ps
// Box predictor and scoreboard for the threshold bounding box unit testbench.
package tbb_box_scoreboard_pkg;
   import tbb_pkg::*;

   class box_scoreboard;
      tbb_cfg_type cfg;
      int          col_count;
      int          row_count;
      int          min_col;
      int          max_col;
      int          min_row;
      int          max_row;
      bit          any_hit;
      tbb_rsp_type expected_boxes[$];
      int          mismatches;

      function new();
         cfg        = CFG_RESET;
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         col_count = 0;
         row_count = 0;
         min_col   = MAX_DIM - 1;
         max_col   = 0;
         min_row   = MAX_DIM - 1;
         max_row   = 0;
         any_hit   = 1'b0;
      endfunction

      function void write_reg(tbb_csr_index_type idx, tbb_dim_type value);
         case (idx)
            CSR_LEVEL_LOW:    cfg.level_low    = value[7:0];
            CSR_LEVEL_HIGH:   cfg.level_high   = value[7:0];
            CSR_MARGIN:       cfg.margin       = value[7:0];
            CSR_IMAGE_WIDTH:  cfg.image_width  = value;
            CSR_IMAGE_HEIGHT: cfg.image_height = value;
            default: ;
         endcase
      endfunction

      // zero acts as one, oversize as MAX_DIM
      function int last_index(tbb_dim_type dim);
         int n;
         n = int'(dim);
         if (n == 0) begin
            n = 1;
         end else if (n > MAX_DIM) begin
            n = MAX_DIM;
         end
         return n - 1;
      endfunction

      function int pending();
         return expected_boxes.size();
      endfunction

      function void note_pixel(tbb_req_type px);
         int          w_last;
         int          h_last;
         int          x;
         int          m;
         int          x0;
         int          x1;
         int          y0;
         int          y1;
         tbb_rsp_type box;
         w_last = last_index(cfg.image_width);
         h_last = last_index(cfg.image_height);
         m      = int'(cfg.margin);
         x      = (col_count > w_last) ? 0 : col_count;
         if (px.pixel_value >= cfg.level_low && px.pixel_value <= cfg.level_high) begin
            if (!any_hit || x < min_col) min_col = x;
            if (!any_hit || x > max_col) max_col = x;
            if (!any_hit || row_count < min_row) min_row = row_count;
            if (!any_hit || row_count > max_row) max_row = row_count;
            any_hit = 1'b1;
         end
         if (!px.frame_end) begin
            if (x >= w_last) begin
               col_count = 0;
               if (row_count < MAX_DIM - 1) row_count++;
            end else begin
               col_count = x + 1;
            end
         end else begin
            box = '0;
            if (!any_hit) begin
               box.box_empty = 1'b1;
            end else begin
               x0 = (min_col > w_last) ? w_last : min_col;
               x1 = (max_col > w_last) ? w_last : max_col;
               y0 = (min_row > h_last) ? h_last : min_row;
               y1 = (max_row > h_last) ? h_last : max_row;
               x0 = (x0 > m) ? x0 - m : 0;
               y0 = (y0 > m) ? y0 - m : 0;
               x1 = (x1 + m > w_last) ? w_last : x1 + m;
               y1 = (y1 + m > h_last) ? h_last : y1 + m;
               box.box_left   = 12'(x0);
               box.box_top    = 12'(y0);
               box.box_width  = 13'(x1 - x0 + 1);
               box.box_height = 13'(y1 - y0 + 1);
            end
            expected_boxes = {expected_boxes, box};
            clear_frame();
         end
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_box(tbb_rsp_type got);
         tbb_rsp_type want;
         if (expected_boxes.size() == 0) begin
            report($sformatf("unexpected box: left %0d top %0d width %0d height %0d empty %0d",
                             got.box_left, got.box_top, got.box_width, got.box_height,
                             got.box_empty));
         end else begin
            want = expected_boxes.pop_front();
            if (got.box_left !== want.box_left || got.box_top !== want.box_top ||
                got.box_width !== want.box_width || got.box_height !== want.box_height ||
                got.box_empty !== want.box_empty) begin
               report($sformatf({"box mismatch: expected left %0d top %0d width %0d ",
                                 "height %0d empty %0d, got left %0d top %0d width %0d ",
                                 "height %0d empty %0d"},
                                want.box_left, want.box_top, want.box_width,
                                want.box_height, want.box_empty, got.box_left, got.box_top,
                                got.box_width, got.box_height, got.box_empty));
            end
         end
      endfunction
   endclass

endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the threshold bounding box unit: pixel and register stimulus, box checks.
module tb_top;
   import tbb_pkg::*;
   import tbb_box_scoreboard_pkg::*;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   tbb_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   tbb_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LEVEL_LOW;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   box_scoreboard sb;

   // stimulus knobs: stretches with no idling on either side
   bit req_no_gap   = 1'b0;
   bit rsp_no_stall = 1'b0;
   int ready_hold   = 0;

   // current threshold range, used to aim pixel values in or out of it
   int cur_lo = 0;
   int cur_hi = 255;
   int pixels_sent = 0;

   always #4 clock = ~clock;

   threshold_bounding_box_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Box beat monitor plus rsp_ready stall pattern. Ready alternates between
   // runs high and stalls, mostly short with the odd long one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_box(rsp_data);
      if (rsp_no_stall) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 6);
      end
   end

   // Idle cycles before a pixel beat: usually none, sometimes a few, rarely many.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Pixel value inside the range with probability hit_pct, otherwise outside
   // it where the range leaves room.
   function automatic tbb_pixel_type pick_pixel(int hit_pct);
      int r;
      r = $urandom_range(0, 99);
      if (cur_lo <= cur_hi && r < hit_pct)
         return tbb_pixel_type'($urandom_range(cur_lo, cur_hi));
      if (cur_lo > 0 && (cur_hi == 255 || r[0]))
         return tbb_pixel_type'($urandom_range(0, cur_lo - 1));
      if (cur_hi < 255) return tbb_pixel_type'($urandom_range(cur_hi + 1, 255));
      return tbb_pixel_type'($urandom_range(0, 255));
   endfunction

   // Mostly small images so rows run past the height; some zero, exactly
   // MAX_DIM and oversize values.
   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 0;
      if (r < 14) return $urandom_range(MAX_DIM + 1, 8191);
      if (r < 18) return MAX_DIM;
      return $urandom_range(1, 12);
   endfunction

   // One pixel beat. Valid is only lowered when a gap follows the previous
   // beat, so back-to-back beats keep it high.
   task automatic send_pixel(input tbb_pixel_type value, input logic last);
      int gap;
      gap = req_no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{pixel_value: value, frame_end: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pixel(req_data);
      pixels_sent++;
   endtask

   task automatic write_reg(input tbb_csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, CSR_DATA_W'(value));
   endtask

   task automatic set_config(input int lo, input int hi, input int margin, input int width,
                             input int height);
      write_reg(CSR_LEVEL_LOW, lo);
      write_reg(CSR_LEVEL_HIGH, hi);
      write_reg(CSR_MARGIN, margin);
      write_reg(CSR_IMAGE_WIDTH, width);
      write_reg(CSR_IMAGE_HEIGHT, height);
      csr_valid <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
   endtask

   // Stop sending, wait for every pending box, then let the result pipe
   // (three stages) run dry before registers are touched.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int v;
      int lo;
      int hi;
      int r;
      int margin;
      int nframes;
      int len;
      int hit;
      int random_base;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---------------- directed part ----------------
      // register defaults: single-pixel frame at full image size
      send_pixel(8'd7, 1'b1);
      settle();

      // inverted range selects nothing -> empty box; zero dims act as one
      set_config(100, 50, 0, 0, 0);
      send_pixel(8'd75, 1'b0);
      send_pixel(8'd100, 1'b0);
      send_pixel(8'd50, 1'b1);
      settle();

      // narrow range, value edges just in and out, frame longer than the
      // height so the kept row is clamped at the result
      set_config(10, 20, 0, 5, 2);
      for (int i = 0; i < 13; i++) begin
         case (i)
            1:       v = 0;
            3:       v = 9;
            6:       v = 10;
            9:       v = 21;
            12:      v = 20;
            default: v = 255;
         endcase
         send_pixel(tbb_pixel_type'(v), i == 12);
      end
      settle();

      // oversize dims act as MAX_DIM; widest margin
      set_config(0, 0, 255, 8191, 8191);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      settle();

      // width shrinks mid-frame: the column count wraps, kept columns clamp
      set_config(200, 255, 2, 6, 6);
      for (int i = 0; i < 5; i++) send_pixel((i == 4) ? 8'd200 : 8'd0, 1'b0);
      settle();
      set_config(200, 255, 2, 3, 6);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd199, 1'b0);
      send_pixel(8'd201, 1'b1);
      settle();

      // ---------------- random part ----------------
      // Each round: fresh registers, a few frames, sometimes a dangling
      // partial frame that the next round's registers then continue.
      random_base = pixels_sent;
      while (pixels_sent - random_base < 420) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            lo = $urandom_range(1, 255);
            hi = $urandom_range(0, lo - 1);
         end else if (r < 20) begin
            lo = $urandom_range(0, 255);
            hi = lo;
         end else if (r < 30) begin
            lo = 0;
            hi = 255;
         end else begin
            lo = $urandom_range(0, 255);
            hi = $urandom_range(0, 255);
            if (lo > hi) begin
               v  = lo;
               lo = hi;
               hi = v;
            end
         end
         r = $urandom_range(0, 99);
         if (r < 30) margin = 0;
         else if (r < 40) margin = 255;
         else if (r < 85) margin = $urandom_range(1, 6);
         else margin = $urandom_range(0, 255);
         set_config(lo, hi, margin, pick_dim(), pick_dim());

         req_no_gap = ($urandom_range(0, 4) == 0);
         rsp_no_stall <= ($urandom_range(0, 3) == 0);
         nframes = $urandom_range(1, 6);
         for (int f = 0; f < nframes; f++) begin
            r = $urandom_range(0, 99);
            if (r < 75) len = $urandom_range(1, 16);
            else if (r < 95) len = $urandom_range(17, 48);
            else len = 1;
            case ($urandom_range(0, 3))
               0:       hit = 0;
               1:       hit = 10;
               2:       hit = 40;
               default: hit = 90;
            endcase
            for (int i = 0; i < len; i++) send_pixel(pick_pixel(hit), i == len - 1);
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 10)) send_pixel(pick_pixel(40), 1'b0);
         end
         settle();
      end

      // close whatever partial frame is left so no beat goes unchecked
      send_pixel(pick_pixel(50), 1'b1);
      settle();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog: generous bound on the slowest legal run
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
design/tbb_pkg.sv
design/tbb_csr.sv
design/tbb_tracker.sv
design/tbb_box_calc.sv
design/threshold_bounding_box_unit.sv
sim/tbb_box_scoreboard.sv
sim/tb_top.sv
